@@ sv/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared types, constants and lookup functions for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int CountBits  = 24;
  localparam int CapBits    = 24;
  localparam int PointBits  = 21;
  localparam int MaxResults = 3;

  localparam logic [CapBits-1:0]   CapReset     = 24'hFFFFFF;
  localparam logic [PointBits-1:0] MaxPoint     = 21'h10FFFF;
  localparam logic [9:0]           SurrogateTop = 10'h01B;
  localparam logic [15:0]          HighHalfBase = 16'hD800;
  localparam logic [15:0]          LowHalfBase  = 16'hDC00;
  localparam logic [PointBits-1:0] PairOffset   = 21'h010000;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [1:0]           res_cnt_t;

  typedef enum logic [2:0] {
    MODE_RUN  = 3'b001,
    MODE_STOP = 3'b010,
    MODE_FAIL = 3'b100
  } run_mode_e;

  typedef enum logic {
    KIND_UNIT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // Per-string decoder state.
  typedef struct packed {
    run_mode_e            mode;
    logic [1:0]           tails_left;
    logic [2:0]           seq_len;
    logic [PointBits-1:0] acc;
    logic                 tail_fault;
    count_t               units;
  } str_state_t;

  // One result word.
  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  code_unit;
    count_t       unit_count;
    logic         failed;
    logic         last_of_run;
  } res_t;

  typedef res_t [MaxResults-1:0] res_vec_t;

  // Sequence length from the top five bits of a lead byte; 0 marks a bad lead.
  function automatic logic [2:0] seq_len_of(input logic [4:0] top5);
    logic [2:0] len;
    case (top5) inside
      [5'd0:5'd15]:  len = 3'd1;
      [5'd24:5'd27]: len = 3'd2;
      5'd28, 5'd29:  len = 3'd3;
      5'd30:         len = 3'd4;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Smallest code point allowed for a given length; beyond reach otherwise.
  function automatic logic [22:0] min_point(input logic [2:0] len);
    logic [22:0] p;
    case (len)
      3'd1:    p = 23'd0;
      3'd2:    p = 23'd128;
      3'd3:    p = 23'd2048;
      3'd4:    p = 23'd65536;
      default: p = 23'd4194304;
    endcase
    return p;
  endfunction

endpackage

@@ sv/u8u16_if.sv @@
// ----------------------------------------------------------------------------
// Transcoder channel interfaces
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8u16_out_if;
  import u8u16_pkg::*;

  logic         valid;
  logic         ready;
  logic         result_kind;
  logic [15:0]  code_unit;
  count_t       unit_count;
  logic         failed;
  logic         last_of_run;

  modport source (output valid, output result_kind, output code_unit, output unit_count,
                  output failed, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input code_unit, input unit_count,
                  input failed, input last_of_run, output ready);
endinterface

@@ sv/utf8_to_utf16_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder core
// A byte's first result word passes the input register and then the result
// register before it is valid.
// Throughput: one byte per cycle unless the output stalls; a byte yielding two or
// three words holds the result buffer until the single output port takes them all.
// Reset clears the string state and the buffers and sets the capacity to
// 0xFFFFFF.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [u8u16_pkg::CapBits-1:0] cfg_wdata_i,
  u8u16_in_if.sink                      in_i,
  u8u16_out_if.source                   out_o
);
  import u8u16_pkg::*;

  logic [CapBits-1:0] cap_q;
  str_state_t         state_q, state_d;
  logic               inq_valid_q;
  logic [7:0]         inq_byte_q;
  logic               inq_last_q;
  res_vec_t           res_q, res_new;
  res_cnt_t           res_cnt_q, res_cnt_new;
  logic               pop;
  logic               move;

  u8u16_decode u_decode (
    .state_i     (state_q),
    .in_byte_i   (inq_byte_q),
    .last_byte_i (inq_last_q),
    .capacity_i  (cap_q),
    .state_o     (state_d),
    .res_o       (res_new),
    .res_cnt_o   (res_cnt_new)
  );

  assign pop  = (res_cnt_q != 2'd0) && out_o.ready;
  // A buffered byte is decoded once the result buffer is empty or drains now.
  assign move = inq_valid_q && ((res_cnt_q == 2'd0) || (pop && (res_cnt_q == 2'd1)));
  assign in_i.ready = !inq_valid_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      inq_byte_q <= in_i.in_byte;
      inq_last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '{mode: MODE_RUN, tails_left: '0, seq_len: '0, acc: '0,
                     tail_fault: 1'b0, units: '0};
      res_cnt_q <= '0;
    end else if (move) begin
      state_q   <= state_d;
      res_cnt_q <= res_cnt_new;
    end else if (pop) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_new;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign out_o.valid       = res_cnt_q != 2'd0;
  assign out_o.result_kind = res_q[0].kind;
  assign out_o.code_unit   = res_q[0].code_unit;
  assign out_o.unit_count  = res_q[0].unit_count;
  assign out_o.failed      = res_q[0].failed;
  assign out_o.last_of_run = res_q[0].last_of_run;

endmodule

@@ sv/u8u16_decode.sv @@
// ----------------------------------------------------------------------------
// Transcoder byte decoder
// Combinational step: one byte and the string state give the next state and
// up to three result words.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  u8u16_pkg::str_state_t     state_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      last_byte_i,
  input  logic [u8u16_pkg::CapBits-1:0] capacity_i,
  output u8u16_pkg::str_state_t     state_o,
  output u8u16_pkg::res_vec_t       res_o,
  output u8u16_pkg::res_cnt_t       res_cnt_o
);
  import u8u16_pkg::*;

  str_state_t           st;
  res_vec_t             res;
  res_cnt_t             n;
  logic [2:0]           len;
  logic                 have_point;
  logic [PointBits-1:0] cp;
  logic [PointBits-1:0] acc_new;
  logic [PointBits-1:0] v;
  logic                 need_pair;
  logic [CountBits:0]   uw_ext;
  logic [CountBits:0]   lim_ext;
  logic                 bad;

  always_comb begin
    st         = state_i;
    res        = '0;
    n          = '0;
    have_point = 1'b0;
    cp         = '0;
    len        = seq_len_of(in_byte_i[7:3]);
    acc_new    = {st.acc[PointBits-7:0], in_byte_i[5:0]};
    bad        = 1'b0;
    lim_ext    = {1'b0, count_t'(capacity_i)};
    uw_ext     = {1'b0, st.units};

    if (st.mode == MODE_RUN) begin
      if (st.tails_left == 2'd0) begin
        if (in_byte_i == 8'h00) begin
          st.mode = MODE_STOP;
        end else if (uw_ext >= lim_ext) begin
          st.mode = MODE_STOP;
        end else if (len == 3'd0) begin
          st.mode = MODE_FAIL;
        end else if (len == 3'd1) begin
          have_point = 1'b1;
          cp         = PointBits'(in_byte_i);
        end else begin
          st.seq_len    = len;
          st.acc        = PointBits'(in_byte_i & lead_mask(len));
          st.tails_left = 2'(len - 3'd1);
          st.tail_fault = 1'b0;
        end
      end else begin
        if (in_byte_i[7:6] != 2'b10) begin
          st.tail_fault = 1'b1;
        end
        st.acc        = acc_new;
        st.tails_left = st.tails_left - 2'd1;
        if (st.tails_left == 2'd0) begin
          bad = st.tail_fault || (st.seq_len > 3'd4) ||
                ({2'b00, acc_new} < min_point(st.seq_len)) ||
                (acc_new[PointBits-1:11] == SurrogateTop) ||
                (acc_new > MaxPoint);
          if (bad) begin
            st.mode = MODE_FAIL;
          end else begin
            have_point = 1'b1;
            cp         = acc_new;
          end
        end
      end
    end

    need_pair = cp[PointBits-1:16] != '0;
    v         = cp - PairOffset;
    if (have_point) begin
      // Stop cleanly when the units needed do not fit under the limit.
      if ((uw_ext > lim_ext) ||
          ((uw_ext + (CountBits+1)'(need_pair ? 2 : 1)) > lim_ext)) begin
        st.mode = MODE_STOP;
      end else if (!need_pair) begin
        st.units             = st.units + 1'b1;
        res[0].kind          = KIND_UNIT;
        res[0].code_unit     = cp[15:0];
        res[0].unit_count    = st.units;
        n                    = 2'd1;
      end else begin
        res[0].kind          = KIND_UNIT;
        res[0].code_unit     = HighHalfBase | {6'd0, v[19:10]};
        res[0].unit_count    = st.units + 1'b1;
        res[1].kind          = KIND_UNIT;
        res[1].code_unit     = LowHalfBase | {6'd0, v[9:0]};
        res[1].unit_count    = st.units + 2'd2;
        st.units             = st.units + 2'd2;
        n                    = 2'd2;
      end
    end

    if (last_byte_i && (st.mode == MODE_RUN) && (st.tails_left != 2'd0)) begin
      st.mode = MODE_FAIL;
    end

    if (last_byte_i) begin
      res[n].kind       = KIND_SUMMARY;
      res[n].code_unit  = '0;
      res[n].unit_count = st.units;
      res[n].failed     = (st.mode == MODE_FAIL);
      n                 = n + 2'd1;
      st                = '0;
      st.mode           = MODE_RUN;
    end

    for (int i = 0; i < MaxResults; i++) begin
      res[i].last_of_run = (n == 2'(i + 1));
    end

    state_o   = st;
    res_o     = res;
    res_cnt_o = n;
  end

endmodule

@@ tb/utf8_to_utf16_transcoder_core_test.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder core testbench
// Streams UTF-8 strings into the core under several output capacities and
// checks every UTF-16 word and end-of-string summary against a cycle-free
// decoder kept in step with the accepted bytes. Both channels idle at random,
// and the result side holds off for long stretches to back up the input.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core_test;
  import u8u16_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int LongHold      = 120;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we    = 1'b0;
  logic [CapBits-1:0] cfg_wdata = '0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       drv_last  = 1'b0;
  logic       mon_ready = 1'b0;

  u8u16_in_if  byte_if ();
  u8u16_out_if word_if ();

  assign byte_if.valid     = drv_valid;
  assign byte_if.in_byte   = drv_byte;
  assign byte_if.last_byte = drv_last;
  assign word_if.ready     = mon_ready;

  utf8_to_utf16_transcoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_if),
    .out_o       (word_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder state, kept in step with the bytes the core accepts.
  run_mode_e            str_mode       = MODE_RUN;
  logic [1:0]           str_tails      = '0;
  logic [2:0]           str_len        = '0;
  logic [PointBits-1:0] str_acc        = '0;
  logic                 str_tail_fault = 1'b0;
  count_t               str_units      = '0;
  logic [CapBits-1:0]   capacity       = CapReset;

  res_t       words_due[$];
  byte_item_t bytes_to_send[$];
  logic [7:0] string_bytes[$];
  int         staged;

  bit steady = 1'b0;
  int error_count       = 0;
  int bytes_queued      = 0;
  int strings_queued    = 0;
  int settings_used     = 1;
  int words_seen        = 0;
  int units_checked     = 0;
  int summaries_checked = 0;
  int failed_summaries  = 0;
  int send_gap          = 0;
  int recv_gap          = 0;
  int hold_left         = 0;
  int quiet_cycles      = 0;
  res_t want;

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void stage_word(input result_kind_e kind, input logic [15:0] unit,
                                     input count_t count, input logic failed);
    res_t w;
    w.kind        = kind;
    w.code_unit   = unit;
    w.unit_count  = count;
    w.failed      = failed;
    w.last_of_run = 1'b0;
    words_due.push_back(w);
    staged++;
  endfunction

  function automatic longint unit_limit();
    longint lim;
    longint count_max;
    count_max = (longint'(1) << CountBits) - 1;
    lim = longint'(capacity);
    if (lim > count_max) lim = count_max;
    return lim;
  endfunction

  // Writes one or two UTF-16 units, or stops the string when they do not fit.
  function automatic void emit_point(input logic [PointBits-1:0] cp);
    longint lim;
    longint need;
    logic [PointBits-1:0] v;
    lim  = unit_limit();
    need = (cp > 21'h00FFFF) ? 2 : 1;
    if (longint'(str_units) > lim || lim - longint'(str_units) < need) begin
      str_mode = MODE_STOP;
    end else if (need == 1) begin
      str_units = str_units + 1'b1;
      stage_word(KIND_UNIT, cp[15:0], str_units, 1'b0);
    end else begin
      v = cp - PairOffset;
      str_units = str_units + 1'b1;
      stage_word(KIND_UNIT, HighHalfBase | {6'd0, v[19:10]}, str_units, 1'b0);
      str_units = str_units + 1'b1;
      stage_word(KIND_UNIT, LowHalfBase | {6'd0, v[9:0]}, str_units, 1'b0);
    end
  endfunction

  // Advances the decoder by one byte and queues the words that byte yields.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [PointBits-1:0] cp;
    int   floor_point;
    logic bad;
    res_t w;
    staged = 0;
    if (str_mode == MODE_RUN) begin
      if (str_tails == 2'd0) begin
        if (b == 8'h00) begin
          str_mode = MODE_STOP;
        end else if (longint'(str_units) >= unit_limit()) begin
          str_mode = MODE_STOP;
        end else if (b < 8'h80) begin
          emit_point({13'd0, b});
        end else if (b >= 8'hC0 && b < 8'hE0) begin
          str_len = 3'd2;
          str_acc = {16'd0, b[4:0]};
          str_tails = 2'd1;
          str_tail_fault = 1'b0;
        end else if (b >= 8'hE0 && b < 8'hF0) begin
          str_len = 3'd3;
          str_acc = {17'd0, b[3:0]};
          str_tails = 2'd2;
          str_tail_fault = 1'b0;
        end else if (b >= 8'hF0 && b < 8'hF8) begin
          str_len = 3'd4;
          str_acc = {18'd0, b[2:0]};
          str_tails = 2'd3;
          str_tail_fault = 1'b0;
        end else begin
          str_mode = MODE_FAIL;
        end
      end else begin
        if (b[7:6] != 2'b10) str_tail_fault = 1'b1;
        str_acc = {str_acc[14:0], b[5:0]};
        str_tails = str_tails - 1'b1;
        if (str_tails == 2'd0) begin
          cp = str_acc;
          case (str_len)
            3'd1:    floor_point = 0;
            3'd2:    floor_point = 128;
            3'd3:    floor_point = 2048;
            3'd4:    floor_point = 65536;
            default: floor_point = 4194304;
          endcase
          bad = str_tail_fault || str_len > 3'd4 || int'(cp) < floor_point ||
                cp[20:11] == SurrogateTop || cp > MaxPoint;
          if (bad) str_mode = MODE_FAIL;
          else emit_point(cp);
        end
      end
      // A string that ends inside a sequence is an error.
      if (last && str_mode == MODE_RUN && str_tails != 2'd0) str_mode = MODE_FAIL;
    end
    if (last) begin
      stage_word(KIND_SUMMARY, 16'h0000, str_units, str_mode == MODE_FAIL);
      str_mode       = MODE_RUN;
      str_tails      = '0;
      str_len        = '0;
      str_acc        = '0;
      str_tail_fault = 1'b0;
      str_units      = '0;
    end
    if (staged > 0) begin
      w = words_due.pop_back();
      w.last_of_run = 1'b1;
      words_due.push_back(w);
    end
  endfunction

  task automatic add_byte(input logic [7:0] b);
    string_bytes.push_back(b);
  endtask

  // Encodes a code point in the given number of bytes, overlong if asked.
  task automatic add_point(input logic [PointBits-1:0] cp, input int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic flush_string(input bit cut);
    byte_item_t item;
    if (cut && string_bytes.size() > 1) void'(string_bytes.pop_back());
    while (string_bytes.size() > 0) begin
      item.data = string_bytes.pop_front();
      item.last = (string_bytes.size() == 0);
      bytes_to_send.push_back(item);
      bytes_queued++;
    end
    strings_queued++;
  endtask

  // Mostly well-formed strings, with the odd broken sequence or stray byte.
  task automatic random_string();
    int points;
    int pick;
    int len;
    logic [PointBits-1:0] cp;
    logic [7:0] b;
    points = $urandom_range(1, 6);
    for (int i = 0; i < points; i++) begin
      if ($urandom_range(0, 9) != 0) begin
        pick = $urandom_range(1, 4);
        case (pick)
          1: cp = PointBits'($urandom_range(1, 'h7F));
          2: cp = PointBits'($urandom_range('h80, 'h7FF));
          3: begin
            cp = PointBits'($urandom_range('h800, 'hF7FF));
            if (cp >= 21'h00D800) cp = cp + 21'h000800;
          end
          default: cp = PointBits'($urandom_range('h10000, 'h10FFFF));
        endcase
        add_point(cp, pick);
      end else begin
        case ($urandom_range(0, 6))
          0: add_byte(8'($urandom_range(0, 255)));
          1: begin
            add_byte(8'hC0 | 8'($urandom_range(2, 31)));
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            add_byte(b);
          end
          2: begin
            len = $urandom_range(2, 4);
            cp  = PointBits'($urandom_range(0, (len == 2) ? 'h7F :
                                               (len == 3) ? 'h7FF : 'hFFFF));
            add_point(cp, len);
          end
          3: add_point(PointBits'($urandom_range('hD800, 'hDFFF)), 3);
          4: add_point(PointBits'($urandom_range('h110000, 'h1FFFFF)), 4);
          5: add_byte(8'h00);
          default: add_byte(8'($urandom_range(0, 1) ? $urandom_range('h80, 'hBF)
                                                    : $urandom_range('hF8, 'hFF)));
        endcase
      end
    end
    flush_string($urandom_range(0, 11) == 0);
  endtask

  task automatic fill_random(input int budget);
    int target;
    target = bytes_queued + budget;
    while (bytes_queued < target) random_string();
  endtask

  // Returns once every byte is sent and every word has come back, then lets
  // the pipeline drain bytes that yield no word.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || words_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CapBits-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    capacity = value;
    settings_used++;
  endtask

  // Byte driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (drv_valid && byte_if.ready) begin
        decode_byte(drv_byte, drv_last);
        void'(bytes_to_send.pop_front());
        send_gap = steady ? 0 : $urandom_range(0, 3);
      end
      // A byte on offer and not yet taken stays as it is.
      if (!drv_valid || byte_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          drv_valid <= 1'b1;
          drv_byte  <= bytes_to_send[0].data;
          drv_last  <= bytes_to_send[0].last;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      mon_ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (mon_ready && word_if.valid) begin
        words_seen++;
        if (words_due.size() == 0) begin
          flag_error($sformatf("unexpected word kind=%0d unit=%h count=%0d failed=%0d last=%0d",
                               word_if.result_kind, word_if.code_unit, word_if.unit_count,
                               word_if.failed, word_if.last_of_run));
        end else begin
          want = words_due.pop_front();
          if (want.kind == KIND_SUMMARY) begin
            summaries_checked++;
            if (want.failed) failed_summaries++;
          end else begin
            units_checked++;
          end
          if (word_if.result_kind !== want.kind || word_if.code_unit !== want.code_unit ||
              word_if.unit_count !== want.unit_count || word_if.failed !== want.failed ||
              word_if.last_of_run !== want.last_of_run) begin
            flag_error($sformatf({"word %0d: got kind=%0d unit=%h count=%0d failed=%0d ",
                                  "last=%0d, want kind=%0d unit=%h count=%0d failed=%0d last=%0d"},
                                 words_seen, word_if.result_kind, word_if.code_unit,
                                 word_if.unit_count, word_if.failed, word_if.last_of_run,
                                 want.kind, want.code_unit, want.unit_count, want.failed,
                                 want.last_of_run));
          end
        end
        recv_gap = steady ? 0 : $urandom_range(0, 3);
        // Long hold-offs let the core fill up and push back on the byte side.
        if (words_seen == 40 || words_seen == 300) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        mon_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((drv_valid && byte_if.ready) || (mon_ready && word_if.valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset capacity: extremes, each error and the stop cases.
    add_point(21'h41, 1);
    add_point(21'h10FFFF, 4);
    flush_string(1'b0);
    add_byte(8'h00);
    add_byte(8'h41);
    flush_string(1'b0);
    add_byte(8'h80);
    flush_string(1'b0);
    add_byte(8'hFF);
    add_byte(8'h41);
    flush_string(1'b0);
    add_byte(8'hC2);
    add_byte(8'h41);
    flush_string(1'b0);
    add_point(21'h0, 2);
    flush_string(1'b0);
    add_point(21'hD800, 3);
    flush_string(1'b0);
    add_point(21'h110000, 4);
    flush_string(1'b0);
    add_point(21'h800, 3);
    flush_string(1'b1);
    add_byte(8'hE4);
    add_byte(8'h00);
    add_byte(8'h80);
    flush_string(1'b0);
    fill_random(60);

    wait_idle();
    set_capacity('0);
    add_point(21'h41, 1);
    flush_string(1'b0);
    fill_random(20);

    // With room for one unit, a pair does not fit and a second point stops.
    wait_idle();
    set_capacity(24'd1);
    add_point(21'h10000, 4);
    flush_string(1'b0);
    add_point(21'h41, 1);
    add_point(21'h42, 1);
    flush_string(1'b0);
    fill_random(40);

    wait_idle();
    set_capacity(24'd2);
    add_point(21'h41, 1);
    add_point(21'h10000, 4);
    flush_string(1'b0);
    fill_random(50);

    wait_idle();
    set_capacity(CapBits'($urandom_range(3, 12)));
    fill_random(70);

    wait_idle();
    set_capacity(CapReset);
    steady = 1'b1;
    fill_random(60);

    wait_idle();
    steady = 1'b0;
    set_capacity(CapBits'($urandom_range(13, 'hFFFFFE)));
    fill_random(60);

    wait_idle();
    if (words_due.size() != 0) flag_error($sformatf("%0d words never arrived", words_due.size()));
    $display("Sent %0d bytes in %0d strings under %0d capacity settings.",
             bytes_queued, strings_queued, settings_used);
    $display("Checked %0d UTF-16 units and %0d summaries, %0d of them failed strings.",
             units_checked, summaries_checked, failed_summaries);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ utf8_to_utf16_transcoder_core.f @@
sv/u8u16_pkg.sv
sv/u8u16_if.sv
sv/u8u16_decode.sv
sv/utf8_to_utf16_transcoder_core.sv
tb/utf8_to_utf16_transcoder_core_test.sv
